@@ src/ffa_pkg.sv @@
// Shared types and constants for the first-fit free-list allocator.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none
package ffa_pkg;
    // arena size in header units and bytes per unit; the datapath link and size widths are fixed at 12 and 13 bits
    localparam int ARENA_UNITS = 4096;
    localparam int UNIT_BYTES  = 16;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [1:0] ST_GRANTED  = 2'd0;
    localparam logic [1:0] ST_RELEASED = 2'd1;
    localparam logic [1:0] ST_ZERO     = 2'd2;
    localparam logic [1:0] ST_OOM      = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ARD0, S_ARD1, S_ACHK,
        S_PLINK0, S_PLINK1, S_PCHK,
        S_PNEXT0, S_PNEXT1, S_PMRG1,
        S_PCUR0, S_PCUR1, S_PMRG2,
        S_ARES,
        S_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input word
        logic a_start;   // alloc walk start: cur := rover, prev := rover, read link(rover)
        logic a_rd;      // step cur to the returned link
        logic a_check;   // evaluate cur header
        logic p_start;   // placement start
        logic p_rd;      // read link(cur)
        logic p_check;   // evaluate placement step
        logic p_rdnext;  // read header of nxt and blk
        logic p_merge1;  // merge with upper neighbor
        logic p_rdcur;   // read header of cur
        logic p_merge2;  // merge with lower neighbor
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_release;
        logic rel_null;
        logic zero_size;
        logic fit;         // current block fits (alloc done)
        logic wrap;        // walk back at rover
        logic oom;         // claim does not fit or walk runaway
        logic runaway;     // allocation walk has run past its step limit
        logic place_found; // placement position reached
        logic from_alloc;  // placement was started by an allocation claim
    } stat_t;
endpackage
`default_nettype wire

@@ src/ffa_datapath.sv @@
// Datapath: header memories, walk registers and result register.
// Depends on ffa_pkg.
`default_nettype none
module ffa_datapath (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire ffa_pkg::cmd_t cmd,
    input  wire logic         in_command,
    input  wire logic [15:0]  in_bytes,
    input  wire logic [11:0]  in_addr,
    output ffa_pkg::stat_t    stat,
    output logic [11:0]       res_addr,
    output logic [1:0]        res_status
);
    localparam int ARENA_UNITS = ffa_pkg::ARENA_UNITS;
    localparam int UNIT_BYTES  = ffa_pkg::UNIT_BYTES;
    localparam int AW = $clog2(ARENA_UNITS);
    localparam int SHIFT = $clog2(UNIT_BYTES);
    localparam int WALK_LIM = 2 * ARENA_UNITS + 2;
    localparam int SW = $clog2(WALK_LIM + 2) + 1;

    logic [11:0] link_mem [ARENA_UNITS];
    logic [12:0] size_mem [ARENA_UNITS];

    // values are kept 18 bits wide; index checks for out-of-range reads
    logic [17:0] rover_reg, top_reg, prev_reg, cur_reg, blk_reg, nxt_reg, need_reg;
    logic [SW-1:0] steps_reg, psteps_reg;
    logic        cmd_reg, zero_reg, null_reg, from_alloc_reg;
    logic [17:0] rd_link_a, rd_size_a, rd_link_b, rd_size_b;
    logic [17:0] ra_a, ra_b;   // read addresses for next cycle data
    logic [17:0] rdla_q, rdsa_q, rdlb_q, rdsb_q;

    // write ports
    logic        wl_en, ws_en;
    logic [17:0] wl_idx, ws_idx, wl_val, ws_val;
    logic        ws2_en;
    logic [17:0] ws2_idx, ws2_val;

    function automatic logic inr(input logic [17:0] i);
        return i < 18'(ARENA_UNITS);
    endfunction

    // read port A and B, registered
    always_ff @(posedge aclk) begin
        rdla_q <= inr(ra_a) ? 18'(link_mem[ra_a[AW-1:0]]) : 18'd0;
        rdsa_q <= inr(ra_a) ? 18'(size_mem[ra_a[AW-1:0]]) : 18'd0;
        rdlb_q <= inr(ra_b) ? 18'(link_mem[ra_b[AW-1:0]]) : 18'd0;
        rdsb_q <= inr(ra_b) ? 18'(size_mem[ra_b[AW-1:0]]) : 18'd0;
        if (!aresetn) begin
            link_mem[0] <= '0;
            size_mem[0] <= '0;
        end else begin
            if (wl_en && inr(wl_idx)) link_mem[wl_idx[AW-1:0]] <= wl_val[11:0];
            if (ws_en && inr(ws_idx)) size_mem[ws_idx[AW-1:0]] <= ws_val[12:0];
            if (ws2_en && inr(ws2_idx)) size_mem[ws2_idx[AW-1:0]] <= ws2_val[12:0];
        end
    end
    assign rd_link_a = rdla_q;
    assign rd_size_a = rdsa_q;
    assign rd_link_b = rdlb_q;
    assign rd_size_b = rdsb_q;

    logic [17:0] need_c, tail_c, plink_m;
    assign need_c = (18'(in_bytes) + 18'(UNIT_BYTES - 1)) >> SHIFT;
    assign plink_m = 18'(rd_link_a[AW-1:0]);

    logic sz_ge, sz_eq, at_rov, claim_ok, runaway, pf;
    assign sz_ge = rd_size_a >= need_reg;
    assign sz_eq = rd_size_a == need_reg;
    assign at_rov = cur_reg == rover_reg;
    assign claim_ok = (top_reg + need_reg) <= 18'(ARENA_UNITS);
    assign runaway = steps_reg > SW'(WALK_LIM);
    assign tail_c = cur_reg + rd_size_a - need_reg;
    assign pf = (blk_reg > cur_reg && blk_reg < rd_link_a) ||
                (cur_reg >= rd_link_a && (blk_reg > cur_reg || blk_reg < rd_link_a)) ||
                (psteps_reg > SW'(ARENA_UNITS));

    assign stat.is_release = cmd_reg;
    assign stat.rel_null   = null_reg;
    assign stat.zero_size  = zero_reg;
    assign stat.fit        = sz_ge;
    assign stat.wrap       = at_rov && !sz_ge;
    assign stat.oom        = (at_rov && !sz_ge && !claim_ok) ||
                             (!sz_ge && !(at_rov) && runaway) ||
                             (!sz_ge && at_rov && claim_ok && 1'b0);
    assign stat.runaway    = runaway;
    assign stat.place_found = pf;
    assign stat.from_alloc = from_alloc_reg;

    always_comb begin
        ra_a = cur_reg; ra_b = blk_reg;
        wl_en = 1'b0; ws_en = 1'b0; ws2_en = 1'b0;
        wl_idx = '0; ws_idx = '0; wl_val = '0; ws_val = '0;
        ws2_idx = '0; ws2_val = '0;
        if (cmd.a_start) ra_a = rover_reg;
        if (cmd.p_rdnext) begin
            ra_a = nxt_reg; ra_b = blk_reg;
        end
        if (cmd.a_check && sz_ge) begin
            if (sz_eq) begin
                wl_en = 1'b1; wl_idx = prev_reg; wl_val = plink_m;
            end else begin
                ws_en = 1'b1; ws_idx = tail_c; ws_val = need_reg;
                ws2_en = 1'b1; ws2_idx = cur_reg; ws2_val = rd_size_a - need_reg;
            end
        end
        if (cmd.a_check && !sz_ge && at_rov && claim_ok) begin
            ws_en = 1'b1; ws_idx = top_reg; ws_val = need_reg;
        end
        if (cmd.p_merge1) begin
            // rd_a: nxt header, rd_b: blk header
            if (blk_reg + rd_size_b == nxt_reg) begin
                ws_en = 1'b1; ws_idx = blk_reg; ws_val = rd_size_b + rd_size_a;
                wl_en = 1'b1; wl_idx = blk_reg; wl_val = plink_m;
            end else begin
                wl_en = 1'b1; wl_idx = blk_reg; wl_val = 18'(nxt_reg[AW-1:0]);
            end
        end
        if (cmd.p_merge2) begin
            // rd_a: cur header, rd_b: blk header (after merge1)
            if (cur_reg + rd_size_a == blk_reg) begin
                ws_en = 1'b1; ws_idx = cur_reg; ws_val = rd_size_a + rd_size_b;
                wl_en = 1'b1; wl_idx = cur_reg; wl_val = 18'(rd_link_b[AW-1:0]);
            end else begin
                wl_en = 1'b1; wl_idx = cur_reg; wl_val = 18'(blk_reg[AW-1:0]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rover_reg <= '0;
            top_reg <= 18'd1;
            res_status <= ffa_pkg::ST_RELEASED;
        end else begin
            if (cmd.load) begin
                cmd_reg <= in_command;
                zero_reg <= in_bytes == 16'd0;
                null_reg <= in_addr == 12'd0;
                need_reg <= need_c + 18'd1;
                blk_reg <= 18'(in_addr) - 18'd1;
                from_alloc_reg <= 1'b0;
                res_addr <= '0;
                res_status <= in_command ? ffa_pkg::ST_RELEASED :
                              (in_bytes == 16'd0 ? ffa_pkg::ST_ZERO : ffa_pkg::ST_OOM);
                steps_reg <= '0;
            end
            if (cmd.a_start) begin
                prev_reg <= rover_reg;
                cur_reg <= rover_reg;
            end
            if (cmd.a_rd && !cmd.a_start) begin
                // link of the walk start has returned: move to that block
                cur_reg <= rd_link_a;
            end
            if (cmd.a_check) begin
                if (sz_ge) begin
                    rover_reg <= prev_reg;
                    res_status <= ffa_pkg::ST_GRANTED;
                    res_addr <= sz_eq ? 12'(cur_reg + 18'd1) : 12'(tail_c + 18'd1);
                end else if (at_rov && !claim_ok) begin
                    res_status <= ffa_pkg::ST_OOM;
                end else if (at_rov) begin
                    top_reg <= (top_reg + need_reg) & 18'h1FFF;
                    blk_reg <= top_reg;
                    from_alloc_reg <= 1'b1;
                    // hold the wrapped block; the walk resumes from its link
                    prev_reg <= cur_reg;
                end else begin
                    steps_reg <= steps_reg + SW'(1);
                    prev_reg <= cur_reg;
                    cur_reg <= rd_link_a;
                end
            end
            if (cmd.p_start) begin
                cur_reg <= rover_reg;
                psteps_reg <= '0;
            end
            if (cmd.p_check) begin
                nxt_reg <= rd_link_a;
                if (!pf) begin
                    cur_reg <= rd_link_a;
                    psteps_reg <= psteps_reg + SW'(1);
                end
            end
            if (cmd.p_merge2) begin
                rover_reg <= cur_reg;
                if (from_alloc_reg && !runaway) begin
                    cur_reg <= prev_reg;
                    steps_reg <= steps_reg + SW'(1);
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ src/ffa_controller.sv @@
// Controller: sequences the allocation walk, placement and result handshake.
// Depends on ffa_pkg.
`default_nettype none
module ffa_controller (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  wire ffa_pkg::stat_t stat,
    output ffa_pkg::cmd_t      cmd
);
    ffa_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ffa_pkg::S_IDLE;
        else state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ffa_pkg::S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load = 1'b1;
                    state_next = ffa_pkg::S_ARD0;
                end
            end
            ffa_pkg::S_ARD0: begin
                if (stat.is_release) begin
                    state_next = stat.rel_null ? ffa_pkg::S_OUT : ffa_pkg::S_PLINK0;
                    cmd.p_start = !stat.rel_null;
                end else if (stat.zero_size) begin
                    state_next = ffa_pkg::S_OUT;
                end else begin
                    cmd.a_start = 1'b1;
                    state_next = ffa_pkg::S_ARD1;
                end
            end
            ffa_pkg::S_ARD1: begin
                // link of cur (rover, or the wrapped block on resume) is on the read port: step cur to it
                cmd.a_rd = 1'b1;
                state_next = ffa_pkg::S_ACHK;
            end
            ffa_pkg::S_ACHK: begin
                // wait for the registered read of the cur header
                state_next = ffa_pkg::S_PCUR0;
            end
            ffa_pkg::S_PCUR0: begin
                cmd.a_check = 1'b1;
                if (stat.fit || stat.oom) state_next = ffa_pkg::S_OUT;
                else if (stat.wrap) begin
                    cmd.p_start = 1'b1;
                    state_next = ffa_pkg::S_PLINK0;
                end else state_next = ffa_pkg::S_ACHK;
            end
            ffa_pkg::S_PLINK0: begin
                cmd.p_rd = 1'b1;
                state_next = ffa_pkg::S_PCHK;
            end
            ffa_pkg::S_PCHK: begin
                cmd.p_check = 1'b1;
                state_next = stat.place_found ? ffa_pkg::S_PNEXT0 : ffa_pkg::S_PLINK0;
            end
            ffa_pkg::S_PNEXT0: begin
                cmd.p_rdnext = 1'b1;
                state_next = ffa_pkg::S_PNEXT1;
            end
            ffa_pkg::S_PNEXT1: begin
                // hold the nxt address so its header is on the port at merge
                cmd.p_rdnext = 1'b1;
                state_next = ffa_pkg::S_PMRG1;
            end
            ffa_pkg::S_PMRG1: begin
                cmd.p_merge1 = 1'b1;
                state_next = ffa_pkg::S_PCUR1;
            end
            ffa_pkg::S_PCUR1: begin
                cmd.p_rdcur = 1'b1;
                state_next = ffa_pkg::S_PLINK1;
            end
            ffa_pkg::S_PLINK1: state_next = ffa_pkg::S_PMRG2;
            ffa_pkg::S_PMRG2: begin
                cmd.p_merge2 = 1'b1;
                // after a claim the walk continues unless it has run away
                if (stat.from_alloc && !stat.runaway) state_next = ffa_pkg::S_ARES;
                else state_next = ffa_pkg::S_OUT;
            end
            ffa_pkg::S_ARES: begin
                // read the link of the wrapped block after the merge writes
                state_next = ffa_pkg::S_ARD1;
            end
            ffa_pkg::S_OUT: begin
                out_valid = 1'b1;
                if (out_ready) state_next = ffa_pkg::S_IDLE;
            end
            default: state_next = ffa_pkg::S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_in_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready |-> state_reg == ffa_pkg::S_IDLE) else $error("ready outside idle");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(in_ready && out_valid)) else $error("ready with result pending");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
`endif
endmodule
`default_nettype wire

@@ src/first_fit_free_list_allocator.sv @@
// First-fit free-list allocator: one request in, one result out, one request at a time.
// Release of address zero and a zero-size request go straight from accept to the result.
// An allocation reads the rover link and then examines free-list blocks one at a time;
// each claim from the arena adds placement steps, a merge and a resume of the walk.
// A release walks the placement steps, merges and then presents the result.
// A result holds the input off until it is taken. Arena and unit sizes are package
// constants. No clearing pass is needed after reset.
// Depends on ffa_pkg, ffa_controller and ffa_datapath.
`default_nettype none
module first_fit_free_list_allocator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // request_bytes[15:0], release_address[27:16]
    input  wire logic        s_tuser,  // command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata   // grant_address[11:0], status[13:12]
);
    ffa_pkg::cmd_t  cmd;
    ffa_pkg::stat_t stat;
    logic [11:0] res_addr;
    logic [1:0]  res_status;

    ffa_controller u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .stat(stat), .cmd(cmd)
    );

    ffa_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd),
        .in_command(s_tuser), .in_bytes(s_tdata[15:0]), .in_addr(s_tdata[27:16]),
        .stat(stat), .res_addr(res_addr), .res_status(res_status)
    );

    assign m_tdata = {2'b00, res_status, res_addr};
endmodule
`default_nettype wire
